/* rtl/dpsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dpsd_pkg;

  // field widths
  localparam int STICK_W = 16;
  localparam int SPEED_W = 16;
  localparam int MV_W    = 15;
  localparam int GAIN_W  = 16;
  localparam int TOP_W   = 15;
  localparam int ERR_W   = 18;
  localparam int SUM_W   = 32;
  localparam int DIFF_W  = 19;

  // shared divider: |speed| << 15 over top speed
  localparam int DIV_NUM_W = 31;
  localparam int DIV_DEN_W = 15;
  localparam int DIV_CNT_W = 5;

  // shared multiplier: unsigned Q8.8 gain times signed operand, then /256
  localparam int MUL_GAIN_W = GAIN_W;
  localparam int MUL_OP_W   = 33;
  localparam int MUL_PROD_W = 48;
  localparam int MUL_Q_W    = MUL_PROD_W - 8;

  localparam int ACC_W = 42;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TOP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOVERNOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BROWNOUT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd7;

  // reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd256;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;
  localparam logic [TOP_W-1:0]  LOW_TOP_RST    = 15'd1000;
  localparam logic [TOP_W-1:0]  HIGH_TOP_RST   = 15'd2000;
  localparam logic [14:0]       GOVERNOR_RST   = 15'd32767;
  localparam logic [MV_W-1:0]   BROWNOUT_RST   = 15'd7000;
  localparam logic [14:0]       DEADBAND_RST   = 15'd1638;
  localparam logic [MV_W-1:0]   LOWEST_MV_RST  = 15'd20000;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/dpsd_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module dpsd_div (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire  [dpsd_pkg::DIV_NUM_W-1:0]        numer,
  input  wire  [dpsd_pkg::DIV_DEN_W-1:0]        denom,
  output dpsd_pkg::div_stat_t                   stat,
  output logic [dpsd_pkg::DIV_NUM_W-1:0]        quot
);
  import dpsd_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;

  logic [DIV_DEN_W:0]   trial;
  logic                 fits;
  logic [DIV_DEN_W:0]   diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, num_r[DIV_NUM_W-1]};
    fits  = (trial >= {1'b0, den_r});
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      den_r <= denom;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], fits};
      rem_r <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = num_r;

endmodule

`default_nettype wire

/* rtl/dpsd_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module dpsd_mul (
  input  wire                                   clk,
  input  wire  [dpsd_pkg::MUL_GAIN_W-1:0]       gain,
  input  wire  signed [dpsd_pkg::MUL_OP_W-1:0]  op,
  output logic signed [dpsd_pkg::MUL_Q_W-1:0]   quo
);
  import dpsd_pkg::*;

  logic signed [MUL_GAIN_W+MUL_OP_W:0] prod_full;
  logic signed [MUL_PROD_W-1:0]        product_r;
  logic signed [MUL_PROD_W-1:0]        rounded;

  assign prod_full = $signed({1'b0, gain}) * op;

  always_ff @(posedge clk) begin
    product_r <= prod_full[MUL_PROD_W-1:0];
  end

  // divide by 256 truncating toward zero
  always_comb begin
    rounded = product_r + $signed({{(MUL_PROD_W-8){1'b0}}, {8{product_r[MUL_PROD_W-1]}}});
    quo     = rounded[MUL_PROD_W-1:8];
  end

endmodule

`default_nettype wire

/* rtl/dual_pid_speed_drive.sv */
`timescale 1ns / 1ps
`default_nettype none

// two-channel pid speed loop with speed feedforward, one control tick per word
// input channel: in_valid / in_stall carries both sticks, both encoder rates,
//   the battery voltage and the gear; in_stall is high while a tick is in work
// output channel: out_valid / out_stall carries both drive commands (negated),
//   the lowest battery voltage seen and the brownout flag
// config channel: cfg_valid / cfg_ready, cfg_index picks a register, cfg_data
//   holds the value; cfg_ready is always high, write only while idle
// each side runs the 31-step shared divider for the speed fraction, then
//   three passes through the shared multiplier (p, i, d), an accumulate and
//   a limit step
// a new word is taken only once both sides are done and the result is loaded
// a finished result sits in the output register, so the next word is taken
//   while the receiver stalls; a further finished result waits until the
//   output register empties
// reset: gains and limits return to their defaults, both error sums and last
//   errors clear, the lowest voltage restarts at 20000 mv

module dual_pid_speed_drive (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [dpsd_pkg::STICK_W-1:0]   in_right_stick,
  input  wire  signed [dpsd_pkg::STICK_W-1:0]   in_left_stick,
  input  wire  signed [dpsd_pkg::SPEED_W-1:0]   in_right_speed,
  input  wire  signed [dpsd_pkg::SPEED_W-1:0]   in_left_speed,
  input  wire  [dpsd_pkg::MV_W-1:0]             in_battery_mv,
  input  wire                                   in_gear_high,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [dpsd_pkg::STICK_W-1:0]   out_right_drive,
  output logic signed [dpsd_pkg::STICK_W-1:0]   out_left_drive,
  output logic [dpsd_pkg::MV_W-1:0]             out_lowest_mv,
  output logic                                  out_brownout,
  // configuration
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [dpsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [dpsd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dpsd_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DIV_GO  = 4'd1;
  localparam logic [3:0] ST_DIV_RUN = 4'd2;
  localparam logic [3:0] ST_MUL_P   = 4'd3;
  localparam logic [3:0] ST_MUL_I   = 4'd4;
  localparam logic [3:0] ST_MUL_D   = 4'd5;
  localparam logic [3:0] ST_ACC_D   = 4'd6;
  localparam logic [3:0] ST_LIMIT   = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  // config registers
  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [TOP_W-1:0]  low_top_r, high_top_r;
  logic [14:0]       governor_r;
  logic [MV_W-1:0]   brownout_mv_r;
  logic [14:0]       deadband_r;

  // loop state
  logic signed [SUM_W-1:0] sum_r  [2];
  logic signed [ERR_W-1:0] last_r [2];
  logic [MV_W-1:0]         lowest_r;

  // sequencer
  logic [3:0] state_r, state_nxt;
  logic       side_r;
  logic       out_valid_r;

  // latched tick
  logic signed [STICK_W-1:0] stick_r [2];
  logic signed [SPEED_W-1:0] speed_r [2];
  logic [TOP_W-1:0]          top_r;
  logic                      gear_r;
  logic                      brown_r;

  // per-side working values
  logic signed [ERR_W-1:0]   e_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [STICK_W-1:0] drive_r [2];

  // output payload
  logic signed [STICK_W-1:0] out_right_r, out_left_r;
  logic [MV_W-1:0]           out_lowest_r;
  logic                      out_brown_r;

  logic in_acc, cfg_wr, out_load;
  logic brown_now;
  logic signed [STICK_W-1:0] rs_shaped, ls_shaped;

  function automatic logic signed [STICK_W-1:0] shape_stick(
    input logic signed [STICK_W-1:0] s,
    input logic [14:0]               db,
    input logic                      half
  );
    logic signed [STICK_W:0]   sx;
    logic [STICK_W:0]          mag;
    logic signed [STICK_W-1:0] z;
    sx  = {s[STICK_W-1], s};
    mag = (sx < 0) ? $unsigned(-sx) : $unsigned(sx);
    z   = (mag < {2'b00, db}) ? '0 : s;
    if (half) begin
      z = z >>> 1;
    end
    return z;
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // stick shaping: deadband to zero, then halve on low battery
  assign brown_now = (in_battery_mv < brownout_mv_r);
  assign rs_shaped = shape_stick(in_right_stick, deadband_r, brown_now);
  assign ls_shaped = shape_stick(in_left_stick, deadband_r, brown_now);

  // divider: |speed| << 15 over top speed
  logic signed [SPEED_W-1:0]   cur_speed;
  logic signed [STICK_W-1:0]   cur_stick;
  logic signed [SPEED_W:0]     speed_x;
  logic [SPEED_W-1:0]          speed_mag;
  logic [DIV_NUM_W-1:0]        div_numer;
  logic [DIV_NUM_W-1:0]        div_quot;
  div_stat_t                   div_stat;

  assign cur_speed = speed_r[side_r];
  assign cur_stick = stick_r[side_r];
  assign speed_x   = {cur_speed[SPEED_W-1], cur_speed};
  assign speed_mag = (speed_x < 0) ? SPEED_W'($unsigned(-speed_x)) : SPEED_W'($unsigned(speed_x));
  assign div_numer = {speed_mag, 15'd0};

  dpsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIV_GO),
    .numer (div_numer),
    .denom (top_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // speed fraction, error, integrator and derivative difference
  logic                      f_neg;
  logic [16:0]               f_mag;
  logic signed [ERR_W-1:0]   f_val;
  logic signed [ERR_W:0]     e_wide;
  logic signed [ERR_W-1:0]   e_val;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [DIFF_W-1:0]  diff_val;

  always_comb begin
    f_neg = cur_speed[SPEED_W-1];
    if (f_neg) begin
      f_mag = (div_quot > 31'd65536) ? 17'd65536 : div_quot[16:0];
    end else begin
      f_mag = (div_quot > 31'd65535) ? 17'd65535 : div_quot[16:0];
    end
    f_val    = f_neg ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
    e_wide   = -$signed({{3{cur_stick[STICK_W-1]}}, cur_stick}) - $signed({f_val[ERR_W-1], f_val});
    e_val    = e_wide[ERR_W-1:0];
    sum_wide = $signed({sum_r[side_r][SUM_W-1], sum_r[side_r]})
             + $signed({{(SUM_W-ERR_W+1){e_val[ERR_W-1]}}, e_val});
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? $signed({1'b1, {(SUM_W-1){1'b0}}})
                                : $signed({1'b0, {(SUM_W-1){1'b1}}});
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    diff_val = $signed({e_val[ERR_W-1], e_val}) - $signed({last_r[side_r][ERR_W-1], last_r[side_r]});
  end

  // shared multiplier, operands picked by step
  logic [MUL_GAIN_W-1:0]       mul_gain;
  logic signed [MUL_OP_W-1:0]  mul_op;
  logic signed [MUL_Q_W-1:0]   mul_quo;
  logic signed [ACC_W-1:0]     acc_sum;

  always_comb begin
    case (state_r)
      ST_MUL_I: begin
        mul_gain = integ_gain_r;
        mul_op   = {sum_r[side_r][SUM_W-1], sum_r[side_r]};
      end
      ST_MUL_D: begin
        mul_gain = deriv_gain_r;
        mul_op   = {{(MUL_OP_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
      end
      default: begin
        mul_gain = prop_gain_r;
        mul_op   = {{(MUL_OP_W-ERR_W){e_r[ERR_W-1]}}, e_r};
      end
    endcase
  end

  dpsd_mul u_mul (
    .clk  (clk),
    .gain (mul_gain),
    .op   (mul_op),
    .quo  (mul_quo)
  );

  assign acc_sum = acc_r + $signed({{(ACC_W-MUL_Q_W){mul_quo[MUL_Q_W-1]}}, mul_quo});

  // limiting: governor on overrange, low gear clamp, negate and saturate
  logic                      c_big;
  logic signed [16:0]        gov_x;
  logic signed [16:0]        c1, c2, c1_mag, drv_x;
  logic signed [STICK_W-1:0] drive_val;

  always_comb begin
    gov_x  = $signed({2'b00, governor_r});
    c_big  = (acc_r > 42'sd32768) || (acc_r < -42'sd32768);
    c1     = c_big ? ((acc_r < 0) ? -gov_x : gov_x) : acc_r[16:0];
    c1_mag = (c1 < 0) ? -c1 : c1;
    c2     = (!gear_r && (c1_mag > gov_x)) ? ((c1 < 0) ? -gov_x : gov_x) : c1;
    drv_x  = -c2;
    drive_val = (drv_x > 17'sd32767) ? 16'sh7fff : drv_x[STICK_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = ST_DIV_GO;
      ST_DIV_GO:  state_nxt = ST_DIV_RUN;
      ST_DIV_RUN: if (div_stat.done) state_nxt = ST_MUL_P;
      ST_MUL_P:   state_nxt = ST_MUL_I;
      ST_MUL_I:   state_nxt = ST_MUL_D;
      ST_MUL_D:   state_nxt = ST_ACC_D;
      ST_ACC_D:   state_nxt = ST_LIMIT;
      ST_LIMIT:   state_nxt = side_r ? ST_DONE : ST_DIV_GO;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      side_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      prop_gain_r   <= PROP_GAIN_RST;
      integ_gain_r  <= INTEG_GAIN_RST;
      deriv_gain_r  <= DERIV_GAIN_RST;
      low_top_r     <= LOW_TOP_RST;
      high_top_r    <= HIGH_TOP_RST;
      governor_r    <= GOVERNOR_RST;
      brownout_mv_r <= BROWNOUT_RST;
      deadband_r    <= DEADBAND_RST;
      sum_r[0]      <= '0;
      sum_r[1]      <= '0;
      last_r[0]     <= '0;
      last_r[1]     <= '0;
      lowest_r      <= LOWEST_MV_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (cfg_index)
          REG_PROP_GAIN:  prop_gain_r   <= cfg_data;
          REG_INTEG_GAIN: integ_gain_r  <= cfg_data;
          REG_DERIV_GAIN: deriv_gain_r  <= cfg_data;
          REG_LOW_TOP:    low_top_r     <= cfg_data[TOP_W-1:0];
          REG_HIGH_TOP:   high_top_r    <= cfg_data[TOP_W-1:0];
          REG_GOVERNOR:   governor_r    <= cfg_data[14:0];
          REG_BROWNOUT:   brownout_mv_r <= cfg_data[MV_W-1:0];
          REG_DEADBAND:   deadband_r    <= cfg_data[14:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        side_r <= 1'b0;
        if (in_battery_mv < lowest_r) begin
          lowest_r <= in_battery_mv;
        end
      end else if (state_r == ST_LIMIT) begin
        side_r <= 1'b1;
      end

      // integrator and last error update once the error is known
      if (state_r == ST_DIV_RUN && div_stat.done) begin
        sum_r[side_r]  <= sum_sat;
        last_r[side_r] <= e_val;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stick_r[0] <= rs_shaped;
      stick_r[1] <= ls_shaped;
      speed_r[0] <= in_right_speed;
      speed_r[1] <= in_left_speed;
      gear_r     <= in_gear_high;
      brown_r    <= brown_now;
      // zero top speed counts as one
      if (in_gear_high) begin
        top_r <= (high_top_r == '0) ? TOP_W'(1) : high_top_r;
      end else begin
        top_r <= (low_top_r == '0) ? TOP_W'(1) : low_top_r;
      end
    end

    case (state_r)
      ST_DIV_RUN: begin
        if (div_stat.done) begin
          e_r    <= e_val;
          diff_r <= diff_val;
          acc_r  <= {{(ACC_W-ERR_W){f_val[ERR_W-1]}}, f_val};
        end
      end
      ST_MUL_I, ST_MUL_D, ST_ACC_D: acc_r <= acc_sum;
      ST_LIMIT: drive_r[side_r] <= drive_val;
      default: ;
    endcase

    if (out_load) begin
      out_right_r  <= drive_r[0];
      out_left_r   <= drive_r[1];
      out_lowest_r <= lowest_r;
      out_brown_r  <= brown_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_right_drive = out_right_r;
  assign out_left_drive  = out_left_r;
  assign out_lowest_mv   = out_lowest_r;
  assign out_brownout    = out_brown_r;

  // an accepted word always starts the right side division
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DIV_GO) && !side_r)
    else $error("accepted word did not start the right side");

  // divider results only come back while the sequencer waits for them
  a_div_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV_RUN))
    else $error("divider finished outside its wait step");

  // the divider is never restarted while still busy
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_GO) |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // left side limit step hands over to the result step
  a_left_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIMIT) && side_r |=> (state_r == ST_DONE))
    else $error("left side did not finish into the result step");

  // a free output register is loaded right away
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && !out_valid_r |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not loaded into a free output register");

endmodule

`default_nettype wire
